// ===== design/chnic_pkg.sv =====
// Shared types and constants for the click hit test block.
// Used by chnic_ctrl, chnic_dp and click_hit_test_nearest_icon; no dependencies.
`default_nettype none

package chnic_pkg;

    localparam int COORD_W         = 9;
    localparam int DIST_W          = 19;
    localparam int REGNUM_W        = 5;
    localparam int ICONNUM_W       = 6;
    localparam int DEF_MAX_ICONS   = 32;
    localparam int DEF_MAX_REGIONS = 26;

    localparam logic [1:0] ACT_ICON   = 2'd0;
    localparam logic [1:0] ACT_REGION = 2'd1;
    localparam logic [1:0] ACT_CLICK  = 2'd2;

    typedef struct packed {
        logic [1:0]         action;
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
        logic [COORD_W-1:0] right_x;
        logic [COORD_W-1:0] bottom_y;
    } t_in_item;

    typedef struct packed {
        logic                 hit_region;
        logic [REGNUM_W-1:0]  region_number;
        logic [ICONNUM_W-1:0] icon_number;
        logic                 none_found;
        logic                 last;
    } t_out_item;

    typedef struct packed {
        logic wr_icon;
        logic wr_region;
        logic ld_click;
        logic rscan_init;
        logic ri_dec;
        logic icon_init;
        logic cov_init;
        logic ri_inc;
        logic cov_set;
        logic sel_icon;
        logic sq;
        logic acc;
        logic ii_inc;
        logic emit_init;
        logic ld_hit;
        logic ld_none;
        logic ld_icon;
    } t_cmd;

    typedef struct packed {
        logic rcnt_zero;
        logic ri_zero;
        logic ri_end;
        logic rhit;
        logic icnt_zero;
        logic ii_last;
        logic have;
        logic cand;
        logic out_last;
    } t_sts;

endpackage

`default_nettype wire

// ===== design/chnic_dp.sv =====
// Datapath: icon and region tables, distance memory, scan counters and result register.
// Depends on chnic_pkg; driven by commands from chnic_ctrl.
`default_nettype none

module chnic_dp
    import chnic_pkg::*;
#(
    parameter int MAX_ICONS   = DEF_MAX_ICONS,
    parameter int MAX_REGIONS = DEF_MAX_REGIONS
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_in_item  i_item,
    input  wire t_cmd      i_cmd,
    output t_sts           o_sts,
    output t_out_item      o_out
);

    localparam int IW  = (MAX_ICONS > 1) ? $clog2(MAX_ICONS) : 1;
    localparam int CW  = $clog2(MAX_ICONS + 1);
    localparam int RAW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int RCW = $clog2(MAX_REGIONS + 1);

    logic [2*COORD_W-1:0] r_icon_mem [MAX_ICONS];
    logic [2*COORD_W-1:0] r_icon_rd;
    logic [DIST_W-1:0]    r_dist_mem [MAX_ICONS];
    logic [DIST_W-1:0]    r_dist_rd;
    logic [COORD_W-1:0]   r_rl [MAX_REGIONS];
    logic [COORD_W-1:0]   r_rt [MAX_REGIONS];
    logic [COORD_W-1:0]   r_rr [MAX_REGIONS];
    logic [COORD_W-1:0]   r_rb [MAX_REGIONS];
    logic [MAX_ICONS-1:0] r_vis;
    logic [CW-1:0]        r_icnt, r_ii, r_ties;
    logic [RCW-1:0]       r_rcnt, r_ri;
    logic                 r_cov, r_have;
    logic [DIST_W-1:0]    r_best;
    logic [COORD_W-1:0]   r_px, r_py;
    logic [2*COORD_W-1:0] r_dx2, r_dy2;
    t_out_item            r_out;

    logic [COORD_W-1:0]   icon_x, icon_y, pt_x, pt_y, dx, dy;
    logic [DIST_W-1:0]    dsq;
    logic [RAW-1:0]       raddr;
    logic [IW-1:0]        iaddr;

    assign icon_x = r_icon_rd[2*COORD_W-1:COORD_W];
    assign icon_y = r_icon_rd[COORD_W-1:0];
    assign pt_x   = i_cmd.sel_icon ? icon_x : r_px;
    assign pt_y   = i_cmd.sel_icon ? icon_y : r_py;
    assign dx     = (icon_x > r_px) ? icon_x - r_px : r_px - icon_x;
    assign dy     = (icon_y > r_py) ? icon_y - r_py : r_py - icon_y;
    assign dsq    = {1'b0, r_dx2} + {1'b0, r_dy2};
    assign raddr  = r_ri[RAW-1:0];
    assign iaddr  = r_ii[IW-1:0];

    // Icon and distance memories, registered read at the scan index
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_icon && r_icnt < CW'(MAX_ICONS)) begin
            r_icon_mem[r_icnt[IW-1:0]] <= {i_item.pos_x, i_item.pos_y};
        end
        r_icon_rd <= r_icon_mem[iaddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc) begin
            r_dist_mem[iaddr] <= dsq;
        end
        r_dist_rd <= r_dist_mem[iaddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_region && r_rcnt < RCW'(MAX_REGIONS)) begin
            r_rl[r_rcnt[RAW-1:0]] <= i_item.pos_x;
            r_rt[r_rcnt[RAW-1:0]] <= i_item.pos_y;
            r_rr[r_rcnt[RAW-1:0]] <= i_item.right_x;
            r_rb[r_rcnt[RAW-1:0]] <= i_item.bottom_y;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_icnt <= '0;
            r_rcnt <= '0;
            r_ii   <= '0;
            r_ri   <= '0;
            r_ties <= '0;
            r_cov  <= 1'b0;
            r_have <= 1'b0;
        end else begin
            if (i_cmd.wr_icon && r_icnt < CW'(MAX_ICONS)) begin
                r_icnt <= r_icnt + CW'(1);
            end
            if (i_cmd.wr_region && r_rcnt < RCW'(MAX_REGIONS)) begin
                r_rcnt <= r_rcnt + RCW'(1);
            end
            if (i_cmd.icon_init || i_cmd.emit_init) begin
                r_ii <= '0;
            end else if (i_cmd.ii_inc) begin
                r_ii <= r_ii + CW'(1);
            end
            if (i_cmd.rscan_init) begin
                r_ri <= r_rcnt - RCW'(1);
            end else if (i_cmd.ri_dec) begin
                r_ri <= r_ri - RCW'(1);
            end else if (i_cmd.cov_init) begin
                r_ri <= '0;
            end else if (i_cmd.ri_inc) begin
                r_ri <= r_ri + RCW'(1);
            end
            if (i_cmd.cov_init) begin
                r_cov <= 1'b0;
            end else if (i_cmd.cov_set) begin
                r_cov <= 1'b1;
            end
            if (i_cmd.icon_init) begin
                r_have <= 1'b0;
            end else if (i_cmd.acc && !r_cov && (!r_have || dsq < r_best)) begin
                r_have <= 1'b1;
            end
            if (i_cmd.acc && !r_cov) begin
                if (!r_have || dsq < r_best) begin
                    r_ties <= CW'(1);
                end else if (dsq == r_best) begin
                    r_ties <= r_ties + CW'(1);
                end
            end else if (i_cmd.ld_icon) begin
                r_ties <= r_ties - CW'(1);
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_click) begin
            r_px <= i_item.pos_x;
            r_py <= i_item.pos_y;
        end
        if (i_cmd.sq) begin
            r_dx2 <= dx * dx;
            r_dy2 <= dy * dy;
        end
        if (i_cmd.acc) begin
            r_vis[iaddr] <= !r_cov;
            if (!r_cov && (!r_have || dsq < r_best)) begin
                r_best <= dsq;
            end
        end
        if (i_cmd.ld_hit) begin
            r_out <= '{hit_region: 1'b1, region_number: REGNUM_W'(r_ri) + REGNUM_W'(1),
                       icon_number: '0, none_found: 1'b0, last: 1'b1};
        end else if (i_cmd.ld_none) begin
            r_out <= '{hit_region: 1'b0, region_number: '0, icon_number: '0,
                       none_found: 1'b1, last: 1'b1};
        end else if (i_cmd.ld_icon) begin
            r_out <= '{hit_region: 1'b0, region_number: '0,
                       icon_number: ICONNUM_W'(r_ii) + ICONNUM_W'(1),
                       none_found: 1'b0, last: (r_ties == CW'(1))};
        end
    end

    assign o_sts.rcnt_zero = (r_rcnt == '0);
    assign o_sts.ri_zero   = (r_ri == '0);
    assign o_sts.ri_end    = (r_ri == r_rcnt);
    assign o_sts.rhit      = (r_rl[raddr] <= pt_x) && (pt_x <= r_rr[raddr]) &&
                             (r_rt[raddr] <= pt_y) && (pt_y <= r_rb[raddr]);
    assign o_sts.icnt_zero = (r_icnt == '0);
    assign o_sts.ii_last   = ((r_ii + CW'(1)) == r_icnt);
    assign o_sts.have      = r_have;
    assign o_sts.cand      = r_vis[iaddr] && (r_dist_rd == r_best);
    assign o_sts.out_last  = r_out.last;
    assign o_out           = r_out;

endmodule

`default_nettype wire

// ===== design/chnic_ctrl.sv =====
// Controller state machine: sequences region scan, icon scan and result emission.
// Depends on chnic_pkg; drives chnic_dp through command and status structs.
`default_nettype none

module chnic_ctrl
    import chnic_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic [1:0] i_action,
    input  wire logic       i_out_ready,
    input  wire t_sts       i_sts,
    output logic            o_in_ready,
    output logic            o_out_valid,
    output t_cmd            o_cmd
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_RSCAN = 9'b000000010,
        S_IRD   = 9'b000000100,
        S_COV   = 9'b000001000,
        S_SQ    = 9'b000010000,
        S_ACC   = 9'b000100000,
        S_ERD   = 9'b001000000,
        S_ECHK  = 9'b010000000,
        S_OUT   = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_action)
                        ACT_ICON:   o_cmd.wr_icon = 1'b1;
                        ACT_REGION: o_cmd.wr_region = 1'b1;
                        ACT_CLICK: begin
                            o_cmd.ld_click   = 1'b1;
                            o_cmd.rscan_init = 1'b1;
                            n_state          = S_RSCAN;
                        end
                        default: ;
                    endcase
                end
            end
            S_RSCAN: begin
                if (!i_sts.rcnt_zero && i_sts.rhit) begin
                    o_cmd.ld_hit = 1'b1;
                    n_state      = S_OUT;
                end else if (i_sts.rcnt_zero || i_sts.ri_zero) begin
                    o_cmd.icon_init = 1'b1;
                    if (i_sts.icnt_zero) begin
                        o_cmd.ld_none = 1'b1;
                        n_state       = S_OUT;
                    end else begin
                        n_state = S_IRD;
                    end
                end else begin
                    o_cmd.ri_dec = 1'b1;
                end
            end
            S_IRD: begin
                o_cmd.cov_init = 1'b1;
                n_state        = S_COV;
            end
            S_COV: begin
                o_cmd.sel_icon = 1'b1;
                if (i_sts.ri_end) begin
                    n_state = S_SQ;
                end else if (i_sts.rhit) begin
                    o_cmd.cov_set = 1'b1;
                    n_state       = S_SQ;
                end else begin
                    o_cmd.ri_inc = 1'b1;
                end
            end
            S_SQ: begin
                o_cmd.sq = 1'b1;
                n_state  = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                if (i_sts.ii_last) begin
                    o_cmd.emit_init = 1'b1;
                    n_state         = S_ERD;
                end else begin
                    o_cmd.ii_inc = 1'b1;
                    n_state      = S_IRD;
                end
            end
            S_ERD: begin
                if (!i_sts.have) begin
                    o_cmd.ld_none = 1'b1;
                    n_state       = S_OUT;
                end else begin
                    n_state = S_ECHK;
                end
            end
            S_ECHK: begin
                if (i_sts.cand) begin
                    o_cmd.ld_icon = 1'b1;
                    n_state       = S_OUT;
                end else begin
                    o_cmd.ii_inc = 1'b1;
                    n_state      = S_ERD;
                end
            end
            S_OUT: begin
                if (i_out_ready) begin
                    if (i_sts.out_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.ii_inc = 1'b1;
                        n_state      = S_ERD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// ===== design/click_hit_test_nearest_icon.sv =====
// Add actions are written while idle and leave the block idle. A click scans regions newest
// first, one per cycle; with no hit, each icon is read, checked for cover against the regions,
// then squared and accumulated, and emission then revisits the icons and sends each result.
// One request at a time; results leave from a register.
// Synchronous active-low reset empties both tables; no clearing pass.
`default_nettype none

module click_hit_test_nearest_icon
    import chnic_pkg::*;
#(
    parameter int MAX_ICONS   = DEF_MAX_ICONS,
    parameter int MAX_REGIONS = DEF_MAX_REGIONS
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_item  i_in,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_item      o_out
);

    t_cmd cmd;
    t_sts sts;

    chnic_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_action    (i_in.action),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    chnic_dp #(
        .MAX_ICONS   (MAX_ICONS),
        .MAX_REGIONS (MAX_REGIONS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_in),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// Testbench for click_hit_test_nearest_icon: directed and random requests,
// with a built-in predictor of region hits and nearest visible icons.
// Depends on chnic_pkg and the click_hit_test_nearest_icon RTL.
`timescale 1ns / 1ps
`default_nettype none

module tb;
    import chnic_pkg::*;

    localparam int N_ICONS   = DEF_MAX_ICONS;
    localparam int N_REGIONS = DEF_MAX_REGIONS;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out;

    click_hit_test_nearest_icon u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in(i_in),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out(o_out)
    );

    always #5 i_clk = ~i_clk;

    // predictor state
    logic [8:0] icon_x [N_ICONS];
    logic [8:0] icon_y [N_ICONS];
    int         n_icons;
    logic [8:0] reg_l [N_REGIONS];
    logic [8:0] reg_t [N_REGIONS];
    logic [8:0] reg_r [N_REGIONS];
    logic [8:0] reg_b [N_REGIONS];
    int         n_regions;

    t_out_item  pending_answers[$];
    int         mismatches = 0;
    bit         hold_off = 0;
    int         max_gap = 3;

    function automatic bit contains(int r, logic [8:0] x, logic [8:0] y);
        return reg_l[r] <= x && x <= reg_r[r] && reg_t[r] <= y && y <= reg_b[r];
    endfunction

    function automatic bit is_hidden(logic [8:0] x, logic [8:0] y);
        for (int r = 0; r < n_regions; r++)
            if (contains(r, x, y)) return 1;
        return 0;
    endfunction

    task automatic predict_request(t_in_item req);
        t_out_item ans;
        int        best;
        int        d;
        int        dx;
        int        dy;
        int        ties[$];
        if (req.action == ACT_ICON) begin
            if (n_icons < N_ICONS) begin
                icon_x[n_icons] = req.pos_x;
                icon_y[n_icons] = req.pos_y;
                n_icons++;
            end
        end else if (req.action == ACT_REGION) begin
            if (n_regions < N_REGIONS) begin
                reg_l[n_regions] = req.pos_x;
                reg_t[n_regions] = req.pos_y;
                reg_r[n_regions] = req.right_x;
                reg_b[n_regions] = req.bottom_y;
                n_regions++;
            end
        end else if (req.action == ACT_CLICK) begin
            ans = '0;
            for (int r = n_regions - 1; r >= 0; r--) begin
                if (contains(r, req.pos_x, req.pos_y)) begin
                    ans.hit_region = 1'b1;
                    ans.region_number = 5'(r + 1);
                    ans.last = 1'b1;
                    pending_answers.push_back(ans);
                    return;
                end
            end
            best = -1;
            for (int i = 0; i < n_icons; i++) begin
                if (is_hidden(icon_x[i], icon_y[i])) continue;
                dx = int'(icon_x[i]) - int'(req.pos_x);
                dy = int'(icon_y[i]) - int'(req.pos_y);
                d = dx * dx + dy * dy;
                if (best < 0 || d < best) begin
                    best = d;
                    ties = {i + 1};
                end else if (d == best) begin
                    ties.push_back(i + 1);
                end
            end
            if (ties.size() == 0) begin
                ans.none_found = 1'b1;
                ans.last = 1'b1;
                pending_answers.push_back(ans);
            end else begin
                foreach (ties[k]) begin
                    ans = '0;
                    ans.icon_number = 6'(ties[k]);
                    ans.last = (k == ties.size() - 1);
                    pending_answers.push_back(ans);
                end
            end
        end
    endtask

    task automatic report(string what, t_out_item got, t_out_item want);
        mismatches++;
        $display("MISMATCH %s: got %p want %p at %0t", what, got, want, $realtime);
    endtask

    function automatic int pick_gap();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        return $urandom_range(0, max_gap);
    endfunction

    // send one request; drop valid only for a gap, keep it high back to back
    task automatic send_request(t_in_item req);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in <= req;
        do @(posedge i_clk); while (!o_in_ready);
        predict_request(req);
    endtask

    task automatic send(logic [1:0] act, int x, int y, int rx = 0, int by = 0);
        t_in_item req;
        req.action = act;
        req.pos_x = 9'(x);
        req.pos_y = 9'(y);
        req.right_x = 9'(rx);
        req.bottom_y = 9'(by);
        send_request(req);
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_answers.size() == 0) begin
                report("unexpected result", o_out, '0);
            end else begin
                want = pending_answers.pop_front();
                if (o_out.hit_region !== want.hit_region) report("hit_region", o_out, want);
                else if (o_out.region_number !== want.region_number)
                    report("region_number", o_out, want);
                else if (o_out.icon_number !== want.icon_number)
                    report("icon_number", o_out, want);
                else if (o_out.none_found !== want.none_found)
                    report("none_found", o_out, want);
                else if (o_out.last !== want.last) report("last", o_out, want);
            end
        end
    end

    // receiver stalls
    always @(posedge i_clk) begin
        if (hold_off) i_out_ready <= 1'b0;
        else if ($urandom_range(0, 29) == 0) i_out_ready <= 1'b0;
        else if (!i_out_ready) i_out_ready <= ($urandom_range(0, 3) == 0);
        else i_out_ready <= ($urandom_range(0, 9) != 0);
    end

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (2000) @(posedge i_clk);
    endtask

    function automatic int rc();
        return $urandom_range(0, 9) == 0 ? ($urandom_range(0, 1) ? 499 : 0)
                                         : $urandom_range(0, 499);
    endfunction

    task automatic test_empty_tables();
        send(ACT_CLICK, 0, 0);
        send(ACT_CLICK, 499, 499);
        send(ACT_UNUSED, 499, 499, 499, 499);
    endtask

    task automatic test_directed();
        send(ACT_ICON, 0, 0);
        send(ACT_ICON, 499, 499);
        send(ACT_ICON, 10, 0);
        send(ACT_ICON, 0, 10);
        send(ACT_CLICK, 5, 5);        // tie between icons 3 and 4 and 1
        send(ACT_CLICK, 499, 499);
        send(ACT_CLICK, 257, 256);
        send(ACT_REGION, 0, 0, 499, 499);
        send(ACT_CLICK, 0, 0);        // whole-area region hit
        send(ACT_CLICK, 499, 499);
        send(ACT_REGION, 300, 300, 299, 400);  // empty rectangle
        send(ACT_REGION, 100, 200, 100, 199);  // empty rectangle
        send(ACT_CLICK, 300, 300);
        send(ACT_UNUSED, 0, 0);
    endtask

    task automatic test_all_hidden_then_reset_tables();
        // new tables would need a reset; instead work with what remains
        send(ACT_CLICK, 100, 100);
    endtask

    task automatic test_capacity();
        for (int i = 0; i < N_ICONS + 2; i++) send(ACT_ICON, rc(), rc());
        for (int i = 0; i < N_REGIONS + 2; i++) send(ACT_REGION, 1, 1, 0, 0);
        send(ACT_CLICK, 3, 3);
    endtask

    task automatic test_backpressure();
        fork
            begin
                hold_off = 1;
                repeat (3000) @(posedge i_clk);
                hold_off = 0;
            end
            for (int i = 0; i < 6; i++) send(ACT_CLICK, rc(), rc());
        join
    endtask

    // random scenes: icons, regions (mostly small) and unused actions, mixed with clicks
    task automatic test_random_scene(int n_items);
        int act;
        int x;
        int y;
        for (int i = 0; i < n_items; i++) begin
            act = $urandom_range(0, 19);
            x = rc();
            y = rc();
            if (act < 5) send(ACT_ICON, x, y);
            else if (act < 8) send(ACT_REGION, x, y, x + $urandom_range(0, 60),
                                   y + $urandom_range(0, 60));
            else if (act < 9) send(ACT_REGION, x, y, rc(), rc());
            else if (act < 10) send(ACT_UNUSED, x, y, rc(), rc());
            else if (act < 13 && n_icons > 0) begin
                // click equidistant-ish near an icon to provoke ties
                send(ACT_CLICK, icon_x[$urandom_range(0, n_icons - 1)], y);
            end else send(ACT_CLICK, x, y);
            if (i % 50 == 0) max_gap = $urandom_range(0, 1) ? 0 : 4;
        end
    endtask

    initial begin
        n_icons = 0;
        n_regions = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_tables();
        test_directed();
        test_random_scene(400);
        test_all_hidden_then_reset_tables();
        test_capacity();
        test_backpressure();
        drain();
        if (mismatches == 0 && pending_answers.size() == 0)
            $display("click_hit_test_nearest_icon regression: pass");
        else
            $display("click_hit_test_nearest_icon regression: fail");
        $finish;
    end

    initial begin
        #50ms;
        $display("click_hit_test_nearest_icon regression: fail");
        $finish;
    end
endmodule

`default_nettype wire
